// ----- design/dtf_pkg.sv -----
package dtf_pkg;

    localparam int TIME_WIDTH  = 64;
    localparam int FRAC_BITS   = 32;
    localparam int GAIN_WIDTH  = 34;
    localparam int RAW_WIDTH   = 63;
    localparam int COUNT_WIDTH = 32;
    localparam int PADDR_WIDTH = 5;
    localparam int PDATA_WIDTH = 64;
    localparam int PROD_WIDTH  = GAIN_WIDTH + TIME_WIDTH;
    localparam int STEP_CNT_W  = $clog2(TIME_WIDTH + 1);

    typedef logic signed [TIME_WIDTH-1:0] t_time;

    localparam t_time TMAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
    localparam t_time TMIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};

    localparam logic [RAW_WIDTH-1:0] LOOP_PERIOD_RESET = RAW_WIDTH'(64'h1_0000_0000);

    typedef struct packed {
        logic [RAW_WIDTH-1:0] raw_time;
        logic                 restart;
    } t_in_item;

    typedef struct packed {
        t_time filtered_time;
        t_time predicted_next;
        t_time filt_drift;
        t_time dev_drift;
        t_time filt_jitter;
        t_time sys_jitter;
    } t_out_item;

    typedef enum logic [1:0] {
        REG_LOOP_PERIOD = 2'd0,
        REG_PROP_GAIN   = 2'd1,
        REG_INTEG_GAIN  = 2'd2
    } t_reg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC1,
        S_CALC2,
        S_LOAD,
        S_RUN,
        S_APPLY1,
        S_APPLY2,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic calc1;
        logic calc2;
        logic load;
        logic step;
        logic apply1;
        logic apply2;
        logic emit;
    } t_cmd;

    function automatic t_time sat_add(t_time a, t_time b);
        logic signed [TIME_WIDTH:0] s;
        s = {a[TIME_WIDTH-1], a} + {b[TIME_WIDTH-1], b};
        if (s[TIME_WIDTH] != s[TIME_WIDTH-1]) begin
            return s[TIME_WIDTH] ? TMIN : TMAX;
        end
        return s[TIME_WIDTH-1:0];
    endfunction

    function automatic t_time sat_sub(t_time a, t_time b);
        logic signed [TIME_WIDTH:0] s;
        s = {a[TIME_WIDTH-1], a} - {b[TIME_WIDTH-1], b};
        if (s[TIME_WIDTH] != s[TIME_WIDTH-1]) begin
            return s[TIME_WIDTH] ? TMIN : TMAX;
        end
        return s[TIME_WIDTH-1:0];
    endfunction

endpackage

// ----- design/dtf_datapath.sv -----
module dtf_datapath #(
    parameter int COUNT_WIDTH = dtf_pkg::COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dtf_pkg::t_cmd                     i_cmd,
    input  dtf_pkg::t_in_item                 i_in_data,
    input  logic [dtf_pkg::RAW_WIDTH-1:0]     i_loop_period,
    input  logic [dtf_pkg::GAIN_WIDTH-1:0]    i_prop_gain,
    input  logic [dtf_pkg::GAIN_WIDTH-1:0]    i_integ_gain,
    output dtf_pkg::t_out_item                o_out_data
);

    localparam int TW = dtf_pkg::TIME_WIDTH;
    localparam int PW = dtf_pkg::PROD_WIDTH;
    localparam int FB = dtf_pkg::FRAC_BITS;

    // gain product: truncate fraction, clamp magnitude, apply sign
    function automatic dtf_pkg::t_time gain_sat(logic [PW-1:0] acc, logic neg);
        logic [TW-1:0] q;
        q = acc[FB +: TW];
        if (|acc[PW-1:FB+TW]) begin
            return neg ? dtf_pkg::TMIN : dtf_pkg::TMAX;
        end
        if (neg) begin
            if (q > dtf_pkg::TMIN) begin
                return dtf_pkg::TMIN;
            end
            return -q;
        end
        if (q[TW-1]) begin
            return dtf_pkg::TMAX;
        end
        return q;
    endfunction

    dtf_pkg::t_time r_raw, r_pe, r_np, r_lf, r_last_raw, r_ndt, r_fpe, r_rpe;
    dtf_pkg::t_time r_t0, r_tmp_f, r_tmp_r, r_tmp_n, r_gi_sat;
    dtf_pkg::t_time r_fdrift, r_ddrift, r_fj, r_sj;
    logic                   r_init, r_started, r_e_neg, r_d_neg;
    logic [TW-1:0]          r_e_mag, r_dvd;
    logic [COUNT_WIDTH-1:0] r_cnt, r_rem;
    logic [PW-1:0]          r_mcand, r_acc_p, r_acc_i;
    logic [dtf_pkg::GAIN_WIDTH-1:0] r_gp, r_gi;
    dtf_pkg::t_out_item     r_out;

    dtf_pkg::t_time         w_per, w_e, w_gp, w_gi, w_rate;
    logic [COUNT_WIDTH:0]   w_trial;
    logic                   w_ge;

    always_comb begin
        w_per   = {1'b0, i_loop_period};
        w_e     = dtf_pkg::sat_sub(r_raw, r_np);
        w_trial = {r_rem, r_dvd[TW-1]};
        w_ge    = w_trial >= {1'b0, r_cnt};
        w_gp    = gain_sat(r_acc_p, r_e_neg);
        w_gi    = gain_sat(r_acc_i, r_e_neg);
        if (r_cnt == '0) begin
            w_rate = '0;
        end else begin
            w_rate = r_d_neg ? -r_dvd : r_dvd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (i_cmd.calc1) begin
            r_started <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw  <= {1'b0, i_in_data.raw_time};
            r_init <= i_in_data.restart || !r_started;
        end
        if (i_cmd.calc1) begin
            r_last_raw <= r_raw;
            if (r_init) begin
                r_pe  <= w_per;
                r_lf  <= r_raw;
                r_np  <= dtf_pkg::sat_add(r_raw, w_per);
                r_ndt <= r_raw;
                r_cnt <= '0;
            end else begin
                r_e_neg <= w_e[TW-1];
                r_e_mag <= w_e[TW-1] ? -w_e : w_e;
                r_t0    <= r_np;
                r_lf    <= r_np;
                r_tmp_f <= dtf_pkg::sat_sub(r_np, r_lf);
                r_tmp_r <= dtf_pkg::sat_sub(r_raw, r_last_raw);
                r_ndt   <= dtf_pkg::sat_add(r_ndt, w_per);
                if (r_cnt != '1) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
        if (i_cmd.calc2) begin
            if (r_init) begin
                r_fpe <= '0;
                r_rpe <= '0;
            end else begin
                r_fpe <= dtf_pkg::sat_sub(r_tmp_f, w_per);
                r_rpe <= dtf_pkg::sat_sub(r_tmp_r, w_per);
            end
            r_fdrift <= dtf_pkg::sat_sub(r_lf, r_raw);
            r_ddrift <= dtf_pkg::sat_sub(r_ndt, r_raw);
        end
        if (i_cmd.load) begin
            r_mcand <= PW'(r_e_mag);
            r_gp    <= i_prop_gain;
            r_gi    <= i_integ_gain;
            r_acc_p <= '0;
            r_acc_i <= '0;
            r_d_neg <= r_ddrift[TW-1];
            r_dvd   <= r_ddrift[TW-1] ? -r_ddrift : r_ddrift;
            r_rem   <= '0;
        end
        // shift-add multiply and restoring divide share the step count
        if (i_cmd.step) begin
            r_acc_p <= r_acc_p + (r_gp[0] ? r_mcand : '0);
            r_acc_i <= r_acc_i + (r_gi[0] ? r_mcand : '0);
            r_gp    <= r_gp >> 1;
            r_gi    <= r_gi >> 1;
            r_mcand <= r_mcand << 1;
            r_rem   <= w_ge ? COUNT_WIDTH'(w_trial - {1'b0, r_cnt})
                            : w_trial[COUNT_WIDTH-1:0];
            r_dvd   <= {r_dvd[TW-2:0], w_ge};
        end
        if (i_cmd.apply1) begin
            r_tmp_n  <= dtf_pkg::sat_add(r_t0, w_gp);
            r_gi_sat <= w_gi;
            r_fj     <= dtf_pkg::sat_sub(r_fpe, w_rate);
            r_sj     <= dtf_pkg::sat_sub(r_rpe, w_rate);
        end
        if (i_cmd.apply2 && !r_init) begin
            r_np <= dtf_pkg::sat_add(r_tmp_n, r_pe);
            r_pe <= dtf_pkg::sat_add(r_pe, r_gi_sat);
        end
        if (i_cmd.emit) begin
            r_out.filtered_time  <= r_lf;
            r_out.predicted_next <= r_np;
            r_out.filt_drift     <= r_fdrift;
            r_out.dev_drift      <= r_ddrift;
            r_out.filt_jitter    <= r_fj;
            r_out.sys_jitter     <= r_sj;
        end
    end

    assign o_out_data = r_out;

endmodule

// ----- design/dtf_ctrl.sv -----
module dtf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dtf_pkg::t_cmd  o_cmd
);

    localparam int SW = dtf_pkg::STEP_CNT_W;
    localparam logic [SW-1:0] LAST_STEP = SW'(dtf_pkg::TIME_WIDTH - 1);

    dtf_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_step, n_step;
    logic            r_out_valid, n_out_valid;
    dtf_pkg::t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtf_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        w_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            dtf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = dtf_pkg::S_CALC1;
                end
            end
            dtf_pkg::S_CALC1: begin
                w_cmd.calc1 = 1'b1;
                n_state     = dtf_pkg::S_CALC2;
            end
            dtf_pkg::S_CALC2: begin
                w_cmd.calc2 = 1'b1;
                n_state     = dtf_pkg::S_LOAD;
            end
            dtf_pkg::S_LOAD: begin
                w_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = dtf_pkg::S_RUN;
            end
            dtf_pkg::S_RUN: begin
                w_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = dtf_pkg::S_APPLY1;
                end
            end
            dtf_pkg::S_APPLY1: begin
                w_cmd.apply1 = 1'b1;
                n_state      = dtf_pkg::S_APPLY2;
            end
            dtf_pkg::S_APPLY2: begin
                w_cmd.apply2 = 1'b1;
                n_state      = dtf_pkg::S_EMIT;
            end
            dtf_pkg::S_EMIT: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = dtf_pkg::S_IDLE;
                end
            end
            default: n_state = dtf_pkg::S_IDLE;
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == dtf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result written over a pending one");
    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == dtf_pkg::S_CALC1))
        else $error("accepted request not processed");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> (r_out_valid && r_state == dtf_pkg::S_IDLE))
        else $error("result not presented after emit");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtf_pkg::S_RUN) |-> (r_step <= LAST_STEP))
        else $error("step counter overran");
`endif

endmodule

// ----- design/dll_timestamp_filter_unit.sv -----
// channel | direction | handshake               | payload
// input   | in        | i_in_valid / o_in_ready  | i_in_data (raw_time, restart)
// output  | out       | o_out_valid / i_out_ready| o_out_data (six Q31.32 values)
// config  | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// each request passes through the 64-step restoring divider that runs
// alongside the bit-serial gain multipliers
// a new request is taken once the previous one is in the output register
// the output register holds a result while the sink stalls
// reset is synchronous, active low, resets the registers and restarts the loop
module dll_timestamp_filter_unit #(
    parameter int COUNT_WIDTH = dtf_pkg::COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dtf_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dtf_pkg::t_out_item                o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dtf_pkg::PADDR_WIDTH-1:0]   paddr,
    input  logic [dtf_pkg::PDATA_WIDTH-1:0]   pwdata,
    output logic [dtf_pkg::PDATA_WIDTH-1:0]   prdata,
    output logic                              pready
);

    logic [dtf_pkg::RAW_WIDTH-1:0]  r_loop_period;
    logic [dtf_pkg::GAIN_WIDTH-1:0] r_prop_gain, r_integ_gain;
    logic                           w_wr;
    dtf_pkg::t_reg_index            w_index;
    dtf_pkg::t_cmd                  w_cmd;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite && pready;
    assign w_index = dtf_pkg::t_reg_index'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_period <= dtf_pkg::LOOP_PERIOD_RESET;
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
        end else if (w_wr) begin
            unique case (w_index)
                dtf_pkg::REG_LOOP_PERIOD: r_loop_period <= pwdata[dtf_pkg::RAW_WIDTH-1:0];
                dtf_pkg::REG_PROP_GAIN:   r_prop_gain   <= pwdata[dtf_pkg::GAIN_WIDTH-1:0];
                dtf_pkg::REG_INTEG_GAIN:  r_integ_gain  <= pwdata[dtf_pkg::GAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            dtf_pkg::REG_LOOP_PERIOD: prdata = dtf_pkg::PDATA_WIDTH'(r_loop_period);
            dtf_pkg::REG_PROP_GAIN:   prdata = dtf_pkg::PDATA_WIDTH'(r_prop_gain);
            dtf_pkg::REG_INTEG_GAIN:  prdata = dtf_pkg::PDATA_WIDTH'(r_integ_gain);
            default:                  prdata = '0;
        endcase
    end

    dtf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    dtf_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_in_data     (i_in_data),
        .i_loop_period (r_loop_period),
        .i_prop_gain   (r_prop_gain),
        .i_integ_gain  (r_integ_gain),
        .o_out_data    (o_out_data)
    );

endmodule
